// File: hw/rtl/rma_pkg.sv
// Shared constants and types of the ramped moving average unit.
package rma_pkg;

  localparam int WIN_W      = 9;
  localparam int SUM_W      = 40;
  localparam int FRAC_W     = 8;
  localparam int OUT_W      = 40;
  localparam int IN_W       = 32;
  localparam int DIVIDEND_W = SUM_W + FRAC_W;
  localparam int DIV_STEPS  = DIVIDEND_W / 2;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [WIN_W-1:0]      divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

endpackage

// File: hw/rtl/rma_ring.sv
// Sample history memory with one write port and one registered read port.
module rma_ring #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/rma_div.sv
// Iterative restoring divider that retires two quotient bits per cycle.
module rma_div (
  input  logic              clk,
  input  logic              rst,
  input  rma_pkg::div_req_t req,
  output rma_pkg::div_rsp_t rsp
);

  logic [rma_pkg::DIVIDEND_W-1:0] quo;
  logic [rma_pkg::WIN_W-1:0]      rem;
  logic [rma_pkg::WIN_W-1:0]      dvs;
  logic [rma_pkg::DIV_CNT_W-1:0]  cnt;
  logic                           busy;
  logic                           done;

  logic [rma_pkg::WIN_W:0]   r1;
  logic [rma_pkg::WIN_W:0]   r2;
  logic [rma_pkg::WIN_W:0]   r1s;
  logic [rma_pkg::WIN_W:0]   r2s;
  logic                      ge1;
  logic                      ge2;

  always_comb begin
    r1  = {rem, quo[rma_pkg::DIVIDEND_W-1]};
    ge1 = r1 >= {1'b0, dvs};
    r1s = ge1 ? (r1 - {1'b0, dvs}) : r1;
    r2  = {r1s[rma_pkg::WIN_W-1:0], quo[rma_pkg::DIVIDEND_W-2]};
    ge2 = r2 >= {1'b0, dvs};
    r2s = ge2 ? (r2 - {1'b0, dvs}) : r2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= rma_pkg::DIV_CNT_W'(rma_pkg::DIV_STEPS - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      quo <= {quo[rma_pkg::DIVIDEND_W-3:0], ge1, ge2};
      rem <= r2s[rma_pkg::WIN_W-1:0];
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

// File: hw/rtl/ramped_moving_average_unit.sv
// Ramped moving average: top level with the step sequencer and output register.
//
//   channel  | dir | handshake            | content
//   s_*      | in  | s_tvalid / s_tready  | tdata: sample
//   m_*      | out | m_tvalid / m_tready  | tdata: average_q8, tuser: window_full
//   cfg_*    | in  | cfg_we               | window_length
//
// Each accepted sample passes through the ring read and the running sum update,
// the divider, which retires two quotient bits per cycle, and the hand-off of
// the quotient to the output register before a result is loaded, and no new
// sample is accepted until that sequence is through. The input is ready only
// while the sequencer is idle, and a result that is not taken holds the sequencer
// in its last step. Reset is synchronous and clears all control state and the sum.
module ramped_moving_average_unit #(
  parameter int MAX_WINDOW   = 256,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [rma_pkg::IN_W-1:0]  s_tdata,   // [31:0] sample
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [rma_pkg::OUT_W-1:0] m_tdata,   // [39:0] average_q8
  output logic                      m_tuser,   // [0] window_full
  input  logic                      cfg_we,
  input  logic [rma_pkg::WIN_W-1:0] cfg_wdata
);

  localparam int PTR_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int RING_W = (SAMPLE_WIDTH < rma_pkg::IN_W) ? SAMPLE_WIDTH : rma_pkg::IN_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_READ  = 3'd1;
  localparam logic [2:0] ST_SUB   = 3'd2;
  localparam logic [2:0] ST_ADD   = 3'd3;
  localparam logic [2:0] ST_START = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0]                state;
  logic [rma_pkg::WIN_W-1:0] window_length;
  logic [rma_pkg::WIN_W-1:0] win_eff;
  logic [rma_pkg::WIN_W-1:0] win;
  logic [PTR_W-1:0]          wp;
  logic [rma_pkg::WIN_W-1:0] seen;
  logic [rma_pkg::SUM_W-1:0] sum;
  logic [RING_W-1:0]         sample_reg;
  logic                      full;
  logic [RING_W-1:0]         old_sample;
  logic                      ring_we;
  logic                      ring_re;
  logic [rma_pkg::WIN_W:0]   seen_inc;
  logic                      s_fire;
  logic                      out_free;
  rma_pkg::div_req_t         div_req;
  rma_pkg::div_rsp_t         div_rsp;

  always_comb begin
    if (window_length == '0) begin
      win_eff = rma_pkg::WIN_W'(1);
    end else if (32'(window_length) > MAX_WINDOW) begin
      win_eff = rma_pkg::WIN_W'(MAX_WINDOW);
    end else begin
      win_eff = window_length;
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign s_fire   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign ring_re  = (state == ST_READ);
  assign ring_we  = (state == ST_SUB);
  assign seen_inc = {1'b0, seen} + 1'b1;

  assign div_req.start    = (state == ST_START);
  assign div_req.dividend = {sum, rma_pkg::FRAC_W'(0)};
  assign div_req.divisor  = seen;

  rma_ring #(
    .DEPTH  (MAX_WINDOW),
    .ADDR_W (PTR_W),
    .DATA_W (RING_W)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (wp),
    .wdata (sample_reg),
    .re    (ring_re),
    .raddr (wp),
    .rdata (old_sample)
  );

  rma_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= rma_pkg::WIN_W'(20);
    end else if (cfg_we) begin
      window_length <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      sample_reg <= s_tdata[RING_W-1:0];
      win        <= win_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      wp       <= '0;
      seen     <= '0;
      sum      <= '0;
      full     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (state == ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_fire) begin
            if (32'(wp) >= 32'(win_eff)) begin
              wp <= '0;
            end
            state <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_SUB;
        end
        ST_SUB: begin
          if (seen >= win) begin
            sum <= sum - rma_pkg::SUM_W'(old_sample);
          end
          state <= ST_ADD;
        end
        ST_ADD: begin
          sum <= sum + rma_pkg::SUM_W'(sample_reg);
          if (32'(wp) + 1 >= 32'(win)) begin
            wp <= '0;
          end else begin
            wp <= wp + 1'b1;
          end
          if (seen_inc >= {1'b0, win}) begin
            seen <= win;
            full <= 1'b1;
          end else begin
            seen <= seen_inc[rma_pkg::WIN_W-1:0];
            full <= 1'b0;
          end
          state <= ST_START;
        end
        ST_START: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      if (div_rsp.quotient[rma_pkg::DIVIDEND_W-1:rma_pkg::OUT_W] != '0) begin
        m_tdata <= '1;
      end else begin
        m_tdata <= div_rsp.quotient[rma_pkg::OUT_W-1:0];
      end
      m_tuser <= full;
    end
  end

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for the ramped moving average unit.
module tb_top;

  localparam int MAX_WIN      = 256;
  localparam int DRAIN_CYCLES = 40;
  localparam int LONG_HOLD    = 200;
  localparam int HOLD_AT      = 150;

  typedef struct packed {
    logic [rma_pkg::OUT_W-1:0] average_q8;
    logic                      window_full;
  } mean_result_t;

  class mean_scoreboard;
    logic [rma_pkg::IN_W-1:0]  history [MAX_WIN];
    int unsigned               wr_ptr;
    int unsigned               seen;
    logic [rma_pkg::SUM_W-1:0] sum;
    logic [rma_pkg::WIN_W-1:0] window_len;
    mean_result_t              pending_means [$];
    int unsigned               errors;

    function new();
      wr_ptr     = 0;
      seen       = 0;
      sum        = '0;
      window_len = rma_pkg::WIN_W'(20);
      errors     = 0;
      foreach (history[i]) history[i] = '0;
    endfunction

    function void set_window(logic [rma_pkg::WIN_W-1:0] v);
      window_len = v;
    endfunction

    function void note_sample(logic [rma_pkg::IN_W-1:0] s);
      int unsigned                    w;
      logic [rma_pkg::DIVIDEND_W-1:0] q;
      mean_result_t                   r;
      w = (window_len == '0) ? 1 : ((window_len > MAX_WIN) ? MAX_WIN : int'(window_len));
      if (wr_ptr >= w) wr_ptr = 0;
      if (seen >= w) sum = sum - rma_pkg::SUM_W'(history[wr_ptr]);
      history[wr_ptr] = s;
      sum    = sum + rma_pkg::SUM_W'(s);
      wr_ptr = (wr_ptr + 1 >= w) ? 0 : wr_ptr + 1;
      seen   = (seen + 1 >= w) ? w : seen + 1;
      q = {sum, {rma_pkg::FRAC_W{1'b0}}} / rma_pkg::DIVIDEND_W'(seen);
      r.average_q8  = (q > rma_pkg::DIVIDEND_W'({rma_pkg::OUT_W{1'b1}})) ?
                      {rma_pkg::OUT_W{1'b1}} : q[rma_pkg::OUT_W-1:0];
      r.window_full = (seen >= w);
      pending_means = {pending_means, r};
    endfunction

    task report(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_mean(logic [rma_pkg::OUT_W-1:0] avg, logic full);
      mean_result_t e;
      if (pending_means.size() == 0) begin
        report($sformatf("unexpected result average_q8=%h window_full=%b", avg, full));
        return;
      end
      e = pending_means.pop_front();
      if (avg !== e.average_q8) begin
        report($sformatf("average_q8 got %h expected %h", avg, e.average_q8));
      end
      if (full !== e.window_full) begin
        report($sformatf("window_full got %b expected %b", full, e.window_full));
      end
    endtask
  endclass

  logic                      clk;
  logic                      rst;
  logic                      s_tvalid;
  logic                      s_tready;
  logic [rma_pkg::IN_W-1:0]  s_tdata;
  logic                      m_tvalid;
  logic                      m_tready;
  logic [rma_pkg::OUT_W-1:0] m_tdata;
  logic                      m_tuser;
  logic                      cfg_we;
  logic [rma_pkg::WIN_W-1:0] cfg_wdata;

  mean_scoreboard            sb;
  bit                        no_idle;
  int unsigned               samples_sent;
  int unsigned               results_seen;
  int unsigned               windows_written;
  logic [rma_pkg::WIN_W-1:0] phase_windows [11];
  logic [rma_pkg::IN_W-1:0]  corner_samples [16] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001,
    32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h5555_5555,
    32'hAAAA_AAAA, 32'hFFFF_FFFE, 32'h0000_0001, 32'h0000_0000,
    32'hFFFF_FFFF, 32'h0001_0000, 32'h1234_5678, 32'hFFFF_FFFF
  };

  ramped_moving_average_unit #(
    .MAX_WINDOW  (MAX_WIN),
    .SAMPLE_WIDTH(rma_pkg::IN_W)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [rma_pkg::IN_W-1:0] random_sample();
    case ($urandom_range(0, 3))
      0: return rma_pkg::IN_W'($urandom_range(0, 255));
      1: return {rma_pkg::IN_W{1'b1}} - rma_pkg::IN_W'($urandom_range(0, 255));
      default: return rma_pkg::IN_W'($urandom());
    endcase
  endfunction

  task automatic send_sample(logic [rma_pkg::IN_W-1:0] s);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= s;
    do @(posedge clk); while (s_tready !== 1'b1);
    sb.note_sample(s);
    samples_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending_means.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_window(logic [rma_pkg::WIN_W-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_window(v);
    windows_written++;
  endtask

  initial begin : stimulus
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    rst       = 1'b1;
    no_idle   = 1'b0;
    sb        = new();
    phase_windows = '{9'd1, 9'd0, 9'd256, 9'd2, 9'd17, 9'd300, 9'd255, 9'd3, 9'd64,
                      9'd1, 9'd1};
    phase_windows[9]  = rma_pkg::WIN_W'($urandom_range(1, MAX_WIN));
    phase_windows[10] = rma_pkg::WIN_W'($urandom_range(1, MAX_WIN));
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // The full window is filled first so that no later window size reads an unwritten entry.
    write_window({rma_pkg::WIN_W{1'b1}});
    foreach (corner_samples[i]) send_sample(corner_samples[i]);
    for (int i = 0; i < 244; i++) begin
      no_idle = (i >= 60 && i < 100);
      send_sample(random_sample());
    end
    no_idle = 1'b0;

    for (int p = 0; p < 11; p++) begin
      write_window(phase_windows[p]);
      no_idle = (p % 3 == 2);
      for (int i = 0; i < 28; i++) send_sample(random_sample());
    end
    no_idle = 1'b0;

    drain();
    if (sb.pending_means.size() != 0) begin
      sb.report($sformatf("%0d averages never arrived", sb.pending_means.size()));
    end
    $display("Covered %0d samples and %0d averages over %0d window settings,",
             samples_sent, results_seen, windows_written);
    $display("including zero, one, full and oversized windows and a long output stall.");
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : result_sink
    int stall;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (results_seen == HOLD_AT) begin
        stall = LONG_HOLD;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 4);
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
      sb.check_mean(m_tdata, m_tuser);
      results_seen++;
      @(negedge clk);
    end
  end

endmodule

// File: files.f
hw/rtl/rma_pkg.sv
hw/rtl/rma_ring.sv
hw/rtl/rma_div.sv
hw/rtl/ramped_moving_average_unit.sv
dv/tb_top.sv
